/* design/sbsc_pkg.sv */
// Shared types, codes and keyword tables for the buffer size command parser.
package sbsc_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_SET     = 3'd0;
  localparam logic [2:0] PH_BUFSIZE = 3'd1;
  localparam logic [2:0] PH_DIGITS  = 3'd2;
  localparam logic [2:0] PH_LF      = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_INVALID = 3'd5;

  // Field widths
  localparam int unsigned VALUE_W = 37;
  localparam int unsigned MAXV_W  = 34;
  localparam int unsigned PROD_W  = VALUE_W + 4;

  // Keyword lengths
  localparam logic [3:0] SET_LEN     = 4'd3;
  localparam logic [3:0] BUFSIZE_LEN = 4'd10;

  // Characters of the grammar
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [MAXV_W-1:0] MAXV_RESET = 34'd10000000000;

  // Parser state carried from one byte to the next
  typedef struct packed {
    logic [2:0]         phase;
    logic [3:0]         letter_idx;
    logic [VALUE_W-1:0] value;
  } parse_state_t;

  // Letters of SET
  function automatic logic [7:0] set_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h45; // E
      4'd2:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letters of BUFFERSIZE
  function automatic logic [7:0] bufsize_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h42; // B
      4'd1:    c = 8'h55; // U
      4'd2:    c = 8'h46; // F
      4'd3:    c = 8'h46; // F
      4'd4:    c = 8'h45; // E
      4'd5:    c = 8'h52; // R
      4'd6:    c = 8'h53; // S
      4'd7:    c = 8'h49; // I
      4'd8:    c = 8'h5A; // Z
      4'd9:    c = 8'h45; // E
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/sbsc_step.sv */
// Next-state logic of the parser for one received byte.
module sbsc_step (
  input  sbsc_pkg::parse_state_t      cur,
  input  logic                        restart,
  input  logic [7:0]                  data_byte,
  input  logic [sbsc_pkg::MAXV_W-1:0] max_value,
  output sbsc_pkg::parse_state_t      nxt
);
  import sbsc_pkg::*;

  parse_state_t       base;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  sum;
  logic [7:0]         digit;
  logic [7:0]         kw_char;
  logic [3:0]         kw_len;
  logic [2:0]         kw_next;

  // Apply restart before the byte is handled
  always_comb begin
    if (restart) begin
      base = '{phase: PH_SET, letter_idx: 4'd0, value: '0};
    end else begin
      base = cur;
    end
  end

  // Multiply-accumulate for a decimal digit: value*10 + digit
  assign digit = data_byte - CH_ZERO;
  assign prod  = {1'b0, base.value, 3'b000} + {3'b000, base.value, 1'b0};
  assign sum   = prod + {{(PROD_W-8){1'b0}}, digit};

  // Select the keyword being matched
  always_comb begin
    if (base.phase == PH_SET) begin
      kw_char = set_char(base.letter_idx);
      kw_len  = SET_LEN;
      kw_next = PH_BUFSIZE;
    end else begin
      kw_char = bufsize_char(base.letter_idx);
      kw_len  = BUFSIZE_LEN;
      kw_next = PH_DIGITS;
    end
  end

  // Advance the grammar by one byte
  always_comb begin
    nxt = base;
    case (base.phase)
      PH_SET, PH_BUFSIZE: begin
        if (base.letter_idx >= kw_len) begin
          if (data_byte == CH_BAR) begin
            nxt.letter_idx = 4'd0;
            nxt.phase      = kw_next;
          end else begin
            nxt.phase = PH_INVALID;
          end
        end else if (data_byte == kw_char) begin
          nxt.letter_idx = base.letter_idx + 4'd1;
        end else begin
          nxt.phase = PH_INVALID;
        end
      end
      PH_DIGITS: begin
        if (data_byte inside {[CH_ZERO:CH_NINE]}) begin
          if (sum > {{(PROD_W-MAXV_W){1'b0}}, max_value}) begin
            nxt.phase = PH_INVALID;
          end
          // Saturate at the top of the value field
          if (|sum[PROD_W-1:VALUE_W]) begin
            nxt.value = '1;
          end else begin
            nxt.value = sum[VALUE_W-1:0];
          end
        end else if (data_byte == CH_CR) begin
          nxt.phase = PH_LF;
        end else begin
          nxt.phase = PH_INVALID;
        end
      end
      PH_LF: begin
        nxt.phase = (data_byte == CH_LF) ? PH_DONE : PH_INVALID;
      end
      default: begin
        nxt = base;
      end
    endcase
  end

endmodule

/* design/set_buffer_size_command_parser.sv */
// Top level of the SET|BUFFERSIZE|<digits> CR LF command parser.
//
// One byte is taken per clock cycle when the output side is ready: each transfer on the
// input is parsed by combinational next-state logic and its result is held in a one-deep
// output register, shown the cycle after the transfer. The input stays ready while that
// register is empty or being drained. in_tuser carries the restart flag, which returns
// the parser to expecting SET before the byte is handled. The result reports the phase
// (0 SET, 1 BUFFERSIZE, 2 digits, 3 LF, 4 finished, 5 invalid), the value accumulated
// so far and a done flag. cfg_wr_data sets the largest accepted size; write it only
// while no transfer is in flight.
module set_buffer_size_command_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sbsc_pkg::MAXV_W-1:0] cfg_wr_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tuser,   // [0] restart
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata   // [2:0] phase, [39:3] size_value,
                                                  // [40] done_res, [47:41] zero
);
  import sbsc_pkg::*;

  logic [MAXV_W-1:0] max_value_r;
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  logic              out_valid_r;
  logic [47:0]       out_data_r;
  logic [47:0]       out_data_nxt;
  logic              in_xfer;
  logic              done_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Parse one byte
  sbsc_step u_step (
    .cur       (state_r),
    .restart   (in_tuser),
    .data_byte (in_tdata),
    .max_value (max_value_r),
    .nxt       (state_nxt)
  );

  assign done_nxt     = (state_nxt.phase == PH_DONE) || (state_nxt.phase == PH_INVALID);
  assign out_data_nxt = {7'b0, done_nxt, state_nxt.value, state_nxt.phase};

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r <= MAXV_RESET;
    end else if (cfg_wr_en) begin
      max_value_r <= cfg_wr_data;
    end
  end

  // Advance the parser state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_SET, letter_idx: 4'd0, value: '0};
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Output register: load on input transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Finished phase absorbs bytes without restart
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_tuser && state_r.phase == PH_DONE) |=> (state_r.phase == PH_DONE))
    else $error("finished phase left without restart");

  // A restart followed by a byte other than S invalidates the parse
  a_restart_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser && in_tdata != 8'h53) |=> (state_r.phase == PH_INVALID))
    else $error("restart with wrong first letter not invalid");

  // Result held in the output register matches the stored state
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_tdata[2:0] == state_r.phase && out_tdata[39:3] == state_r.value))
    else $error("result register differs from parser state");

  // Letter index never runs beyond the longer keyword
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.letter_idx <= BUFSIZE_LEN)
    else $error("letter index out of range");

  // Input stalls only while a result waits on a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without cause");
`endif

endmodule

/* dv/tb_set_buffer_size_command_parser.sv */
// Self-checking testbench for the SET|BUFFERSIZE|<digits> CR LF command parser.
`timescale 1ns / 100ps

module tb_set_buffer_size_command_parser;
  import sbsc_pkg::*;

  // One parser report: the three fields of a result transfer
  typedef struct packed {
    logic [2:0]         phase;
    logic [VALUE_W-1:0] size_value;
    logic               done;
  } report_t;

  // One byte transfer with its restart flag
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } line_byte_t;

  // Directed row: known is set where the report is written out by hand
  typedef struct packed {
    logic               restart;
    logic [7:0]         data;
    logic               known;
    logic [2:0]         phase;
    logic [VALUE_W-1:0] size_value;
    logic               done;
  } directed_row_t;

  localparam logic [VALUE_W-1:0] VALUE_CEIL = '1;
  localparam int unsigned IDLE_PCT = 17;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned N_DIRECTED = 24;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{1'b1, "S",   1'b1, PH_SET,     37'd0, 1'b0},  // first byte after reset
    '{1'b0, "E",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "T",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "|",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "B",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "U",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "F",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "F",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "E",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "R",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "S",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "I",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "Z",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "E",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "|",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, CH_CR, 1'b1, PH_LF,      37'd0, 1'b0},  // empty digit string
    '{1'b0, CH_LF, 1'b1, PH_DONE,    37'd0, 1'b1},
    '{1'b0, 8'hFF, 1'b1, PH_DONE,    37'd0, 1'b1},  // absorbed once finished
    '{1'b1, 8'h00, 1'b1, PH_INVALID, 37'd0, 1'b1},
    '{1'b0, "9",   1'b1, PH_INVALID, 37'd0, 1'b1},  // absorbed once invalid
    '{1'b1, "S",   1'b0, PH_SET,     37'd0, 1'b0},
    '{1'b0, "|",   1'b1, PH_INVALID, 37'd0, 1'b1},  // bar inside a keyword
    '{1'b1, "|",   1'b1, PH_INVALID, 37'd0, 1'b1},
    '{1'b1, 8'h80, 1'b1, PH_INVALID, 37'd0, 1'b1}
  };

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [MAXV_W-1:0]        cfg_wr_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata = '0;    // [7:0] data_byte
  logic                     in_tuser = 1'b0;  // [0] restart
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [47:0]              out_tdata;        // [2:0] phase, [39:3] size_value,
                                              // [40] done_res, [47:41] zero

  // Predicted parser state and register
  logic [2:0]               model_phase = PH_SET;
  logic [3:0]               model_idx = '0;
  logic [VALUE_W-1:0]       model_value = '0;
  logic [MAXV_W-1:0]        model_max = MAXV_RESET;

  report_t                  pending_reports [$];
  line_byte_t               line_plan [$];
  logic [MAXV_W-1:0]        max_settings [PHASES];
  int unsigned              mismatch_count = 0;
  int unsigned              live_items = 0;
  bit                       quiet = 1'b0;

  set_buffer_size_command_parser u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Match one keyword letter, or the closing bar once the keyword is complete
  function automatic logic [2:0] match_letter(input string word, input logic [7:0] b,
                                              input logic [2:0] next_phase);
    if (model_idx >= word.len()) begin
      if (b == CH_BAR) begin
        model_idx = 4'd0;
        return next_phase;
      end
      return PH_INVALID;
    end
    if (b == word[model_idx]) begin
      model_idx = model_idx + 4'd1;
      return model_phase;
    end
    return PH_INVALID;
  endfunction

  // Advance the predicted parser by one byte and return its report
  function automatic report_t step_parser(input logic restart, input logic [7:0] b);
    logic [PROD_W-1:0] sum;
    report_t           rep;
    if (restart) begin
      model_phase = PH_SET;
      model_idx   = 4'd0;
      model_value = '0;
    end
    case (model_phase)
      PH_SET:     model_phase = match_letter("SET", b, PH_BUFSIZE);
      PH_BUFSIZE: model_phase = match_letter("BUFFERSIZE", b, PH_DIGITS);
      PH_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          sum = {4'd0, model_value} * 41'd10 + {33'd0, b - CH_ZERO};
          if (sum > {7'd0, model_max}) model_phase = PH_INVALID;
          // keep the oversized value, saturated at the field width
          model_value = (sum > {4'd0, VALUE_CEIL}) ? VALUE_CEIL : sum[VALUE_W-1:0];
        end else if (b == CH_CR) begin
          model_phase = PH_LF;
        end else begin
          model_phase = PH_INVALID;
        end
      end
      PH_LF:      model_phase = (b == CH_LF) ? PH_DONE : PH_INVALID;
      default: ;
    endcase
    rep.phase      = model_phase;
    rep.size_value = model_value;
    rep.done       = (model_phase == PH_DONE || model_phase == PH_INVALID);
    return rep;
  endfunction

  // Offer one byte, hold it until the transfer, then record its report
  task automatic send_byte(input logic restart, input logic [7:0] b, input logic known,
                           input report_t known_rep);
    report_t predicted;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    if (restart || (model_phase != PH_DONE && model_phase != PH_INVALID)) live_items++;
    predicted = step_parser(restart, b);
    pending_reports.push_back(known ? known_rep : predicted);
  endtask

  task automatic plan_byte(input logic restart, input logic [7:0] b);
    line_plan.push_back('{restart, b});
  endtask

  task automatic plan_text(input string s, input logic first_restart);
    for (int i = 0; i < s.len(); i++) plan_byte(i == 0 ? first_restart : 1'b0, s[i]);
  endtask

  task automatic plan_digits(input int unsigned n);
    repeat (n) plan_byte(1'b0, CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic plan_number(input longint unsigned n);
    plan_text($sformatf("%0d", n), 1'b0);
  endtask

  // Build one command line: mostly well formed, some damaged or cut short, some noise
  task automatic plan_command();
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(99);
    if (kind < 85) begin
      plan_text("SET|BUFFERSIZE|", $urandom_range(9) != 0);
      case ($urandom_range(9))
        0: ;
        1: plan_number(longint'(model_max));
        2: plan_number(longint'(model_max) + 1);
        3: plan_digits(12);
        4: plan_digits(11);
        5: plan_digits(10);
        6: begin
          // land near a tenth of the saturation point, then push past it with one more digit
          plan_number(64'd13743895347 + longint'($urandom_range(32'd3435973836)));
          plan_digits(1);
        end
        default: plan_digits($urandom_range(1, 6));
      endcase
      plan_byte(1'b0, CH_CR);
      plan_byte(1'b0, CH_LF);
      if (kind < 15) begin
        cut = $urandom_range(line_plan.size() - 1);
        line_plan[cut].data    = 8'($urandom);
        line_plan[cut].restart = ($urandom_range(3) == 0);
      end else if (kind < 30) begin
        cut = $urandom_range(line_plan.size() - 1);
        while (line_plan.size() > cut + 1) void'(line_plan.pop_back());
        plan_byte(1'b0, 8'($urandom));
      end
      repeat ($urandom_range(2)) plan_byte(1'b0, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) plan_byte($urandom_range(3) == 0, 8'($urandom));
    end
  endtask

  task automatic send_plan();
    line_byte_t item;
    while (line_plan.size() != 0) begin
      item = line_plan.pop_front();
      send_byte(item.restart, item.data, 1'b0, '0);
    end
  endtask

  // Drop valid and wait until every report has arrived
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_max(input logic [MAXV_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_max = value;
  endtask

  // Receiver side stalls at random outside the quiet stretches
  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transfer with the oldest predicted report
  always @(posedge clk) begin : report_check
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.phase      = out_tdata[2:0];
      got.size_value = out_tdata[39:3];
      got.done       = out_tdata[40];
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, phase %0d value %0d done %0d",
                 $time, got.phase, got.size_value, got.done);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.phase != want.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
          mismatch_count++;
        end
        if (got.size_value != want.size_value) begin
          $display("%0t: size_value expected %0d actual %0d",
                   $time, want.size_value, got.size_value);
          mismatch_count++;
        end
        if (got.done != want.done) begin
          $display("%0t: done_res expected %0d actual %0d", $time, want.done, got.done);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    max_settings[0] = MAXV_RESET;
    max_settings[1] = '1;
    max_settings[2] = '0;
    max_settings[3] = 34'd10000000000;
    max_settings[4] = {2'($urandom_range(3)), $urandom};
    max_settings[5] = 34'd99999;
    max_settings[6] = '1;
    max_settings[7] = 34'($urandom_range(1000000));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].restart, DIRECTED[i].data, DIRECTED[i].known,
                '{DIRECTED[i].phase, DIRECTED[i].size_value, DIRECTED[i].done});
    end
    live_items = 0;

    // Random phases, each under its own maximum; the first keeps the reset value
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph > 0) write_max(max_settings[ph]);
      quiet = (ph == 3 || ph == 6);
      // finish the line left open in the digit phase, now under the new maximum
      if (ph > 0) begin
        plan_digits($urandom_range(1, 3));
        plan_byte(1'b0, CH_CR);
        plan_byte(1'b0, CH_LF);
        send_plan();
      end
      while (live_items < (ph + 1) * ITEMS_PER_PHASE) begin
        plan_command();
        send_plan();
      end
      // leave a line open in the digit phase across the register write
      plan_text("SET|BUFFERSIZE|", 1'b1);
      plan_digits($urandom_range(1, 5));
      send_plan();
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
design/sbsc_pkg.sv
design/sbsc_step.sv
design/set_buffer_size_command_parser.sv
dv/tb_set_buffer_size_command_parser.sv
